// ===== src/confirm_retransmit_queue_core_defines.svh =====
// Assertion macros shared by the confirm/retransmit queue RTL.
`ifndef CONFIRM_RETRANSMIT_QUEUE_CORE_DEFINES_SVH
`define CONFIRM_RETRANSMIT_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CRQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: condition must never hold");
`define CRQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define CRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CRQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define CRQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define CRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/crq_pkg.sv =====
// Shared constants, codes and interface structs of the confirm/retransmit queue.
package crq_pkg;

  localparam int TYPE_SLOTS = 4;
  localparam int SLOT_W     = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TYPE_SLOTS + 1);

  localparam int KIND_W       = 2;
  localparam int MSG_TYPE_W   = 3;
  localparam int TYPE_CMP_W   = MSG_TYPE_W + 1;
  localparam int TAG_W        = 64;
  localparam int ENTRY_TYPE_W = 2;
  localparam int PCNT_W       = 3;
  localparam int BACKOFF_W    = 11;

  localparam logic [BACKOFF_W-1:0] BACKOFF_START = BACKOFF_W'(4);
  localparam logic [BACKOFF_W-1:0] BACKOFF_LIMIT = BACKOFF_W'(60 * 10);

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_CONFIRM = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_RESEND  = 2'd3
  } kind_t;

  // Command presented by the input register.
  typedef struct packed {
    logic                  vld;
    kind_t                 kind;
    logic [MSG_TYPE_W-1:0] msg_type;
    logic [TAG_W-1:0]      tag;
  } cmd_t;

  // Slot store status after applying the current command.
  typedef struct packed {
    logic              accepted;
    logic              replaced;
    logic              hit;
    logic [CNT_W-1:0]  count;
    logic              sel_valid;
    logic [SLOT_W-1:0] sel_type;
    logic [TAG_W-1:0]  sel_tag;
  } slot_stat_t;

  // Backoff timer status after applying the current command.
  typedef struct packed {
    logic [BACKOFF_W-1:0] backoff;
    logic                 due;
  } tmr_stat_t;

endpackage

// ===== src/confirm_retransmit_queue_core.sv =====
// Top level of the confirm/retransmit queue: input register, control and result register.
//
// Usage: a command (in_kind, in_msg_type, in_tag) is taken at a rising edge where
// start is high and busy is low. Kinds are enqueue, confirmation, one-second tick
// and resend request. Every result appears on the out_ ports for exactly one cycle,
// marked by out_valid; out_last marks the final result of a command.
// Pipeline: the input register loads at the accepting edge, and the slot compare and
// update run in the following cycle into the result register that drives the out_ ports.
// Throughput: enqueue, confirmation and tick commands never raise busy, so a new
// command may be started every cycle while busy is low. A resend with N pending entries
// produces N results (one when none is pending) on consecutive cycles; for N of two or
// more, busy is high from the cycle after acceptance while the tag-ordered entries are
// stepped out of the slot store.
// Reset (rst_n low, synchronous) empties all slots and sets the backoff interval
// and the countdown to 4 seconds. Results cannot be held off by the receiver, so
// no stall condition exists on the result side.
`include "confirm_retransmit_queue_core_defines.svh"

module confirm_retransmit_queue_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [crq_pkg::KIND_W-1:0]          in_kind,
  input  logic [crq_pkg::MSG_TYPE_W-1:0]      in_msg_type,
  input  logic [crq_pkg::TAG_W-1:0]           in_tag,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic                                out_replaced,
  output logic                                out_due,
  output logic                                out_entry_valid,
  output logic [crq_pkg::ENTRY_TYPE_W-1:0]    out_entry_type,
  output logic [crq_pkg::TAG_W-1:0]           out_entry_tag,
  output logic                                out_last,
  output logic [crq_pkg::PCNT_W-1:0]          out_pending_count,
  output logic [crq_pkg::BACKOFF_W-1:0]       out_backoff_seconds
);

  logic                               in_vld_r;
  crq_pkg::kind_t                     in_kind_r;
  logic [crq_pkg::MSG_TYPE_W-1:0]     in_msg_type_r;
  logic [crq_pkg::TAG_W-1:0]          in_tag_r;

  logic                               emit_active_r;
  logic                               emit_active_nxt;
  logic [crq_pkg::SLOT_W-1:0]         emit_cnt_r;
  logic [crq_pkg::SLOT_W-1:0]         emit_cnt_nxt;

  logic                               out_valid_r;
  logic                               out_accepted_r;
  logic                               out_accepted_nxt;
  logic                               out_replaced_r;
  logic                               out_replaced_nxt;
  logic                               out_due_r;
  logic                               out_entry_valid_r;
  logic                               out_entry_valid_nxt;
  logic [crq_pkg::ENTRY_TYPE_W-1:0]   out_entry_type_r;
  logic [crq_pkg::ENTRY_TYPE_W-1:0]   out_entry_type_nxt;
  logic [crq_pkg::TAG_W-1:0]          out_entry_tag_r;
  logic [crq_pkg::TAG_W-1:0]          out_entry_tag_nxt;
  logic                               out_last_r;
  logic                               out_last_nxt;
  logic [crq_pkg::PCNT_W-1:0]         out_pending_count_r;
  logic [crq_pkg::BACKOFF_W-1:0]      out_backoff_seconds_r;

  crq_pkg::cmd_t                      cmd;
  crq_pkg::slot_stat_t                slot_stat;
  crq_pkg::tmr_stat_t                 tmr_stat;
  logic [crq_pkg::SLOT_W-1:0]         sel_rank;
  logic                               in_take;
  logic                               is_resend;
  logic                               resend_path;
  logic                               multi_resend;
  logic                               emit_done;

  assign cmd = {in_vld_r, in_kind_r, in_msg_type_r, in_tag_r};

  assign sel_rank = emit_active_r ? emit_cnt_r : '0;

  crq_slot_store u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sel_rank (sel_rank),
    .stat     (slot_stat)
  );

  crq_backoff u_backoff (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .hit   (slot_stat.hit),
    .stat  (tmr_stat)
  );

  assign is_resend    = in_vld_r && (in_kind_r == crq_pkg::KIND_RESEND);
  assign resend_path  = is_resend || emit_active_r;
  assign multi_resend = is_resend && (slot_stat.count > crq_pkg::CNT_W'(1));
  assign emit_done    = (crq_pkg::CNT_W'(emit_cnt_r) + crq_pkg::CNT_W'(1)) == slot_stat.count;
  assign busy         = emit_active_r || multi_resend;
  assign in_take      = start && !busy;

  always_comb begin
    out_accepted_nxt    = in_vld_r && slot_stat.accepted;
    out_replaced_nxt    = in_vld_r && slot_stat.replaced;
    out_entry_valid_nxt = resend_path && slot_stat.sel_valid;
    out_entry_type_nxt  = '0;
    out_entry_tag_nxt   = '0;
    if (out_entry_valid_nxt) begin
      out_entry_type_nxt = crq_pkg::ENTRY_TYPE_W'(slot_stat.sel_type);
      out_entry_tag_nxt  = slot_stat.sel_tag;
    end

    emit_active_nxt = emit_active_r;
    emit_cnt_nxt    = emit_cnt_r;
    out_last_nxt    = 1'b1;
    if (emit_active_r) begin
      out_last_nxt = emit_done;
      if (emit_done) begin
        emit_active_nxt = 1'b0;
      end else begin
        emit_cnt_nxt = emit_cnt_r + crq_pkg::SLOT_W'(1);
      end
    end else if (multi_resend) begin
      out_last_nxt    = 1'b0;
      emit_active_nxt = 1'b1;
      emit_cnt_nxt    = crq_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      emit_active_r <= 1'b0;
      emit_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      in_vld_r      <= in_take;
      emit_active_r <= emit_active_nxt;
      emit_cnt_r    <= emit_cnt_nxt;
      out_valid_r   <= in_vld_r || emit_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r     <= crq_pkg::kind_t'(in_kind);
      in_msg_type_r <= in_msg_type;
      in_tag_r      <= in_tag;
    end
    if (in_vld_r || emit_active_r) begin
      out_accepted_r        <= out_accepted_nxt;
      out_replaced_r        <= out_replaced_nxt;
      out_due_r             <= tmr_stat.due;
      out_entry_valid_r     <= out_entry_valid_nxt;
      out_entry_type_r      <= out_entry_type_nxt;
      out_entry_tag_r       <= out_entry_tag_nxt;
      out_last_r            <= out_last_nxt;
      out_pending_count_r   <= crq_pkg::PCNT_W'(slot_stat.count);
      out_backoff_seconds_r <= tmr_stat.backoff;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_accepted_r;
  assign out_replaced        = out_replaced_r;
  assign out_due             = out_due_r;
  assign out_entry_valid     = out_entry_valid_r;
  assign out_entry_type      = out_entry_type_r;
  assign out_entry_tag       = out_entry_tag_r;
  assign out_last            = out_last_r;
  assign out_pending_count   = out_pending_count_r;
  assign out_backoff_seconds = out_backoff_seconds_r;

  // A new transaction never sits in the input register while a resend is being stepped out.
  `CRQ_ASSERT_NEVER(a_no_cmd_during_emit, clk, rst_n, in_vld_r && emit_active_r)
  // A result that is not the last of its transaction is followed by another result.
  `CRQ_ASSERT_NEXT(a_burst_continues, clk, rst_n, out_valid_r && !out_last_r, out_valid_r)
  // While entries are stepped out, the previous cycle produced a non-final resend result.
  `CRQ_ASSERT_IMPLIES(a_emit_has_prev, clk, rst_n, emit_active_r,
                      out_valid_r && !out_last_r && out_entry_valid_r)
  // An accepted transaction lands in the input register on the next cycle.
  `CRQ_ASSERT_NEXT(a_take_loads, clk, rst_n, start && !busy, in_vld_r)

endmodule

// ===== src/crq_slot_store.sv =====
// Pending-entry slots: per-type valid and tag, tag matching and tag-order ranking.
module crq_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crq_pkg::cmd_t                 cmd,
  input  logic [crq_pkg::SLOT_W-1:0]    sel_rank,
  output crq_pkg::slot_stat_t           stat
);

  logic [crq_pkg::TYPE_SLOTS-1:0] slot_valid_r;
  logic [crq_pkg::TYPE_SLOTS-1:0] slot_valid_nxt;
  logic [crq_pkg::TAG_W-1:0]      slot_tag_r [crq_pkg::TYPE_SLOTS];

  logic [crq_pkg::TYPE_SLOTS-1:0] tag_eq;
  logic [crq_pkg::TYPE_SLOTS-1:0] drop;
  logic [crq_pkg::SLOT_W-1:0]     rank [crq_pkg::TYPE_SLOTS];
  logic [crq_pkg::SLOT_W-1:0]     type_idx;
  logic                           type_ok;
  logic                           tag_we;

  assign type_idx = cmd.msg_type[crq_pkg::SLOT_W-1:0];
  assign type_ok  = {1'b0, cmd.msg_type} < crq_pkg::TYPE_CMP_W'(crq_pkg::TYPE_SLOTS);

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    drop           = '0;
    tag_we         = 1'b0;
    stat           = '0;
    for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
      tag_eq[i] = slot_tag_r[i] == cmd.tag;
    end
    if (cmd.vld) begin
      unique case (cmd.kind)
        crq_pkg::KIND_ENQUEUE: begin
          if (type_ok) begin
            for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
              drop[i] = slot_valid_r[i] &&
                        ((crq_pkg::SLOT_W'(i) == type_idx) || tag_eq[i]);
            end
            slot_valid_nxt           = slot_valid_r & ~drop;
            slot_valid_nxt[type_idx] = 1'b1;
            tag_we                   = 1'b1;
            stat.accepted            = 1'b1;
            stat.replaced            = |drop;
          end
        end
        crq_pkg::KIND_CONFIRM: begin
          drop           = slot_valid_r & tag_eq;
          slot_valid_nxt = slot_valid_r & ~drop;
          stat.accepted  = |drop;
          stat.hit       = |drop;
        end
        crq_pkg::KIND_TICK, crq_pkg::KIND_RESEND: begin
        end
        default: begin
        end
      endcase
    end

    for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
      stat.count = stat.count + crq_pkg::CNT_W'(slot_valid_nxt[i]);
    end

    // Rank of a slot is the number of pending slots holding a smaller tag.
    for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < crq_pkg::TYPE_SLOTS; j++) begin
        if (j != i && slot_valid_r[j] && (slot_tag_r[j] < slot_tag_r[i])) begin
          rank[i] = rank[i] + crq_pkg::SLOT_W'(1);
        end
      end
    end

    for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
      if (slot_valid_r[i] && (rank[i] == sel_rank)) begin
        stat.sel_valid = 1'b1;
        stat.sel_type  = stat.sel_type | crq_pkg::SLOT_W'(i);
        stat.sel_tag   = stat.sel_tag | slot_tag_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      slot_tag_r[type_idx] <= cmd.tag;
    end
  end

endmodule

// ===== src/crq_backoff.sv =====
// Backoff interval and resend countdown registers.
module crq_backoff (
  input  logic                clk,
  input  logic                rst_n,
  input  crq_pkg::cmd_t       cmd,
  input  logic                hit,
  output crq_pkg::tmr_stat_t  stat
);

  logic [crq_pkg::BACKOFF_W-1:0] backoff_r;
  logic [crq_pkg::BACKOFF_W-1:0] backoff_nxt;
  logic [crq_pkg::BACKOFF_W-1:0] countdown_r;
  logic [crq_pkg::BACKOFF_W-1:0] countdown_nxt;

  always_comb begin
    backoff_nxt   = backoff_r;
    countdown_nxt = countdown_r;
    if (cmd.vld) begin
      unique case (cmd.kind)
        crq_pkg::KIND_CONFIRM: begin
          if (hit) begin
            backoff_nxt = crq_pkg::BACKOFF_START;
          end
        end
        crq_pkg::KIND_TICK: begin
          if (countdown_r != '0) begin
            countdown_nxt = countdown_r - crq_pkg::BACKOFF_W'(1);
          end
        end
        crq_pkg::KIND_RESEND: begin
          // Doubling drops the top bit, matching an 11-bit interval register.
          if (backoff_r < crq_pkg::BACKOFF_LIMIT) begin
            backoff_nxt = {backoff_r[crq_pkg::BACKOFF_W-2:0], 1'b0};
          end
          countdown_nxt = backoff_nxt;
        end
        crq_pkg::KIND_ENQUEUE: begin
        end
        default: begin
        end
      endcase
    end
    stat.backoff = backoff_nxt;
    stat.due     = countdown_nxt == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r   <= crq_pkg::BACKOFF_START;
      countdown_r <= crq_pkg::BACKOFF_START;
    end else begin
      backoff_r   <= backoff_nxt;
      countdown_r <= countdown_nxt;
    end
  end

endmodule

// ===== tb/confirm_retransmit_queue_core_tb.sv =====
// Self-checking testbench for the confirm/retransmit queue core.
module confirm_retransmit_queue_core_tb;

  localparam int CLK_PERIOD = 12;
  localparam int RUN_LIMIT_CYCLES = 200000;

  typedef struct {
    logic                             accepted;
    logic                             replaced;
    logic                             due;
    logic                             entry_valid;
    logic [crq_pkg::ENTRY_TYPE_W-1:0] entry_type;
    logic [crq_pkg::TAG_W-1:0]        entry_tag;
    logic                             last;
    logic [crq_pkg::PCNT_W-1:0]       pending_count;
    logic [crq_pkg::BACKOFF_W-1:0]    backoff_seconds;
  } queue_result_t;

  // Shadow of the slot store and backoff timer, plus the results still owed by the block.
  class pending_result_board;
    logic                          slot_busy[crq_pkg::TYPE_SLOTS];
    logic [crq_pkg::TAG_W-1:0]     slot_tag[crq_pkg::TYPE_SLOTS];
    logic [crq_pkg::BACKOFF_W-1:0] backoff;
    logic [crq_pkg::BACKOFF_W-1:0] countdown;
    queue_result_t                 awaited[$];
    int                            errors;

    function new();
      for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        slot_tag[i] = '0;
      end
      backoff = crq_pkg::BACKOFF_START;
      countdown = crq_pkg::BACKOFF_START;
      errors = 0;
    endfunction

    function int pending_entries();
      int n;
      n = 0;
      for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
        if (slot_busy[i]) n++;
      end
      return n;
    endfunction

    function void push_result(logic acc, logic rep, logic ev,
                              logic [crq_pkg::ENTRY_TYPE_W-1:0] etype,
                              logic [crq_pkg::TAG_W-1:0] etag, logic last);
      queue_result_t r;
      r.accepted = acc;
      r.replaced = rep;
      r.due = (countdown == 0);
      r.entry_valid = ev;
      r.entry_type = etype;
      r.entry_tag = etag;
      r.last = last;
      r.pending_count = crq_pkg::PCNT_W'(pending_entries());
      r.backoff_seconds = backoff;
      awaited.push_back(r);
    endfunction

    function void note_command(crq_pkg::kind_t kind, logic [crq_pkg::MSG_TYPE_W-1:0] msg_type,
                               logic [crq_pkg::TAG_W-1:0] tag);
      logic hit;
      int   n;
      int   best;
      logic emitted[crq_pkg::TYPE_SLOTS];
      hit = 1'b0;
      case (kind)
        crq_pkg::KIND_ENQUEUE: begin
          if (msg_type >= crq_pkg::TYPE_SLOTS) begin
            push_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
              if (slot_busy[i] && (i == msg_type || slot_tag[i] == tag)) begin
                slot_busy[i] = 1'b0;
                hit = 1'b1;
              end
            end
            slot_busy[msg_type] = 1'b1;
            slot_tag[msg_type] = tag;
            push_result(1'b1, hit, 1'b0, '0, '0, 1'b1);
          end
        end
        crq_pkg::KIND_CONFIRM: begin
          for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
            if (slot_busy[i] && slot_tag[i] == tag) begin
              slot_busy[i] = 1'b0;
              hit = 1'b1;
            end
          end
          if (hit) backoff = crq_pkg::BACKOFF_START;
          push_result(hit, 1'b0, 1'b0, '0, '0, 1'b1);
        end
        crq_pkg::KIND_TICK: begin
          if (countdown != 0) countdown = countdown - 1'b1;
          push_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
        end
        default: begin
          if (backoff < crq_pkg::BACKOFF_LIMIT) backoff = backoff << 1;
          countdown = backoff;
          n = pending_entries();
          if (n == 0) begin
            push_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) emitted[i] = 1'b0;
            // Entries go out in ascending tag order; pending tags are always distinct.
            for (int k = 0; k < n; k++) begin
              best = -1;
              for (int i = 0; i < crq_pkg::TYPE_SLOTS; i++) begin
                if (slot_busy[i] && !emitted[i] && (best < 0 || slot_tag[i] < slot_tag[best]))
                  best = i;
              end
              emitted[best] = 1'b1;
              push_result(1'b0, 1'b0, 1'b1, crq_pkg::ENTRY_TYPE_W'(best), slot_tag[best],
                          k == n - 1);
            end
          end
        end
      endcase
    endfunction

    function void match_field(string field, logic [crq_pkg::TAG_W-1:0] want,
                              logic [crq_pkg::TAG_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction outstanding: expected none, got tag %h",
                 $time, got.entry_tag);
        return;
      end
      want = awaited.pop_front();
      match_field("accepted", want.accepted, got.accepted);
      match_field("replaced", want.replaced, got.replaced);
      match_field("due", want.due, got.due);
      match_field("entry_valid", want.entry_valid, got.entry_valid);
      match_field("entry_type", want.entry_type, got.entry_type);
      match_field("entry_tag", want.entry_tag, got.entry_tag);
      match_field("last", want.last, got.last);
      match_field("pending_count", want.pending_count, got.pending_count);
      match_field("backoff_seconds", want.backoff_seconds, got.backoff_seconds);
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [crq_pkg::KIND_W-1:0]       in_kind = '0;
  logic [crq_pkg::MSG_TYPE_W-1:0]   in_msg_type = '0;
  logic [crq_pkg::TAG_W-1:0]        in_tag = '0;
  logic                             out_valid;
  logic                             out_accepted;
  logic                             out_replaced;
  logic                             out_due;
  logic                             out_entry_valid;
  logic [crq_pkg::ENTRY_TYPE_W-1:0] out_entry_type;
  logic [crq_pkg::TAG_W-1:0]        out_entry_tag;
  logic                             out_last;
  logic [crq_pkg::PCNT_W-1:0]       out_pending_count;
  logic [crq_pkg::BACKOFF_W-1:0]    out_backoff_seconds;

  pending_result_board        board = new();
  queue_result_t              seen_result;
  // Last tag enqueued per type, so that many confirmations hit a pending entry.
  logic [crq_pkg::TAG_W-1:0]  sent_tag[crq_pkg::TYPE_SLOTS] = '{default: '0};

  confirm_retransmit_queue_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_msg_type         (in_msg_type),
    .in_tag              (in_tag),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_replaced        (out_replaced),
    .out_due             (out_due),
    .out_entry_valid     (out_entry_valid),
    .out_entry_type      (out_entry_type),
    .out_entry_tag       (out_entry_tag),
    .out_last            (out_last),
    .out_pending_count   (out_pending_count),
    .out_backoff_seconds (out_backoff_seconds)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results are checked before the transaction taken at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        seen_result.accepted = out_accepted;
        seen_result.replaced = out_replaced;
        seen_result.due = out_due;
        seen_result.entry_valid = out_entry_valid;
        seen_result.entry_type = out_entry_type;
        seen_result.entry_tag = out_entry_tag;
        seen_result.last = out_last;
        seen_result.pending_count = out_pending_count;
        seen_result.backoff_seconds = out_backoff_seconds;
        board.check_result(seen_result);
      end
      if (start && busy === 1'b0)
        board.note_command(crq_pkg::kind_t'(in_kind), in_msg_type, in_tag);
    end
  end

  task automatic issue(crq_pkg::kind_t kind, logic [crq_pkg::MSG_TYPE_W-1:0] msg_type,
                       logic [crq_pkg::TAG_W-1:0] tag);
    start <= 1'b1;
    in_kind <= kind;
    in_msg_type <= msg_type;
    in_tag <= tag;
    do @(posedge clk); while (busy !== 1'b0);
    if (kind == crq_pkg::KIND_ENQUEUE && msg_type < crq_pkg::TYPE_SLOTS)
      sent_tag[msg_type] = tag;
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 4));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [crq_pkg::TAG_W-1:0] rand_tag();
    // Small tags collide often, which exercises replacement by tag.
    if ($urandom_range(0, 2) == 0) return crq_pkg::TAG_W'($urandom_range(0, 7));
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [crq_pkg::MSG_TYPE_W-1:0] rand_type();
    if ($urandom_range(0, 9) == 0)
      return crq_pkg::MSG_TYPE_W'($urandom_range(crq_pkg::TYPE_SLOTS, 7));
    return crq_pkg::MSG_TYPE_W'($urandom_range(0, crq_pkg::TYPE_SLOTS - 1));
  endfunction

  task automatic random_phase(int items, int idle_pct);
    int sel;
    int issued;
    logic [crq_pkg::TAG_W-1:0] tag;
    issued = 0;
    while (issued < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        // A run of resends walks the backoff up to its ceiling.
        repeat (9) begin
          issue(crq_pkg::KIND_RESEND, crq_pkg::MSG_TYPE_W'($urandom()),
                {$urandom(), $urandom()});
          pace(idle_pct);
        end
        issued += 9;
      end else if (sel < 12) begin
        repeat (6) begin
          issue(crq_pkg::KIND_TICK, crq_pkg::MSG_TYPE_W'($urandom()),
                {$urandom(), $urandom()});
          pace(idle_pct);
        end
        issued += 6;
      end else begin
        if (sel < 44) begin
          issue(crq_pkg::KIND_ENQUEUE, rand_type(), rand_tag());
        end else if (sel < 70) begin
          tag = ($urandom_range(0, 9) < 7)
                ? sent_tag[$urandom_range(0, crq_pkg::TYPE_SLOTS - 1)]
                : rand_tag();
          issue(crq_pkg::KIND_CONFIRM, crq_pkg::MSG_TYPE_W'($urandom()), tag);
        end else if (sel < 85) begin
          issue(crq_pkg::KIND_TICK, crq_pkg::MSG_TYPE_W'($urandom()),
                {$urandom(), $urandom()});
        end else begin
          issue(crq_pkg::KIND_RESEND, crq_pkg::MSG_TYPE_W'($urandom()),
                {$urandom(), $urandom()});
        end
        pace(idle_pct);
        issued++;
      end
    end
  endtask

  initial begin
    int settle;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Count down past zero, then a resend with nothing pending.
    repeat (5) issue(crq_pkg::KIND_TICK, '0, '0);
    issue(crq_pkg::KIND_RESEND, 3'd7, '1);
    issue(crq_pkg::KIND_ENQUEUE, 3'd0, 64'h0);
    issue(crq_pkg::KIND_ENQUEUE, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(crq_pkg::KIND_ENQUEUE, 3'd7, 64'h5);
    issue(crq_pkg::KIND_ENQUEUE, 3'd4, 64'h5555_5555_5555_5555);
    issue(crq_pkg::KIND_ENQUEUE, 3'd2, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(crq_pkg::KIND_ENQUEUE, 3'd2, 64'h8000_0000_0000_0001);
    // Same tag as the type 1 entry, so that one is dropped.
    issue(crq_pkg::KIND_ENQUEUE, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(crq_pkg::KIND_ENQUEUE, 3'd1, 64'h0000_0000_0000_0100);
    issue(crq_pkg::KIND_RESEND, '0, '0);
    issue(crq_pkg::KIND_CONFIRM, '0, 64'h0000_0000_0001_2345);
    issue(crq_pkg::KIND_CONFIRM, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(crq_pkg::KIND_ENQUEUE, 3'd3, 64'h0);
    issue(crq_pkg::KIND_RESEND, '0, '0);
    issue(crq_pkg::KIND_CONFIRM, '0, 64'h0000_0000_0000_0100);
    issue(crq_pkg::KIND_CONFIRM, '0, 64'h8000_0000_0000_0001);
    issue(crq_pkg::KIND_CONFIRM, '0, 64'h0);
    issue(crq_pkg::KIND_ENQUEUE, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(crq_pkg::KIND_ENQUEUE, 3'd5, 64'h0);
    drain();

    random_phase(70, 29);
    drain();
    random_phase(70, 62);
    drain();
    random_phase(66, 0);

    start <= 1'b0;
    settle = 0;
    while (board.awaited.size() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (6) @(posedge clk);
    if (board.awaited.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, board.awaited.size());
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * RUN_LIMIT_CYCLES);
    $display("%0t: run did not finish in time", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
